@@ hdl/vlid_pkg.sv @@
// Package for the variable-length instruction decoder: item types, format
// classes and the classify and field-extraction functions.
// No dependencies.
package vlid_pkg;

  typedef enum logic [4:0] {
    CLS_NOP       = 5'd0,
    CLS_RTS       = 5'd1,
    CLS_BRANCH_R  = 5'd2,
    CLS_PUSH      = 5'd3,
    CLS_POP       = 5'd4,
    CLS_PUSHL     = 5'd5,
    CLS_POPL      = 5'd6,
    CLS_LD_IND    = 5'd7,
    CLS_ST_IND    = 5'd8,
    CLS_ALU_REG   = 5'd9,
    CLS_BCOND     = 5'd10,
    CLS_BL        = 5'd11,
    CLS_ALU_IMM5  = 5'd12,
    CLS_LD_OFF    = 5'd13,
    CLS_ST_OFF    = 5'd14,
    CLS_ALU_IMM16 = 5'd15,
    CLS_ALU3_REG  = 5'd16,
    CLS_ALU3_IMM6 = 5'd17,
    CLS_ALU_IMM32 = 5'd18,
    CLS_ADD_IMM32 = 5'd19,
    CLS_UNKNOWN   = 5'd20,
    CLS_TRUNC     = 5'd21
  } fmt_class_e;

  typedef struct packed {
    logic [15:0] halfword;
    logic        last_halfword;
  } in_t;

  typedef struct packed {
    logic [4:0]  format_class;
    logic [1:0]  length_halfwords;
    logic [31:0] instr_address;
    logic [4:0]  opcode_field;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [3:0]  condition;
    logic [31:0] immediate;
    logic [31:0] branch_target;
    logic        end_of_run;
  } out_t;

  typedef struct packed {
    fmt_class_e cls;
    logic [1:0] len;
  } class_info_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic class_info_t classify(logic [15:0] h);
    class_info_t r;
    r.len = 2'd1;
    if (h == 16'h0001)                       r.cls = CLS_NOP;
    else if (h == 16'h005A)                  r.cls = CLS_RTS;
    else if ((h & 16'hFFE0) == 16'h0040)     r.cls = CLS_BRANCH_R;
    else if ((h & 16'hFF90) == 16'h0280)     r.cls = CLS_PUSH;
    else if ((h & 16'hFF90) == 16'h0200)     r.cls = CLS_POP;
    else if ((h & 16'hFF90) == 16'h0380)     r.cls = CLS_PUSHL;
    else if ((h & 16'hFF90) == 16'h0300)     r.cls = CLS_POPL;
    else if ((h & 16'hF900) == 16'h0800)     r.cls = CLS_LD_IND;
    else if ((h & 16'hF900) == 16'h0900)     r.cls = CLS_ST_IND;
    else if ((h & 16'hE000) == 16'h4000)     r.cls = CLS_ALU_REG;
    else if ((h & 16'hF080) == 16'h9000) begin
      r.cls = CLS_BCOND;
      r.len = 2'd2;
    end else if ((h & 16'hF080) == 16'h9080) begin
      r.cls = CLS_BL;
      r.len = 2'd2;
    end else if ((h & 16'hE000) == 16'h6000) r.cls = CLS_ALU_IMM5;
    else if ((h & 16'hFF20) == 16'hA200) begin
      r.cls = CLS_LD_OFF;
      r.len = 2'd2;
    end else if ((h & 16'hFF20) == 16'hA220) begin
      r.cls = CLS_ST_OFF;
      r.len = 2'd2;
    end else if ((h & 16'hFC00) == 16'hB000) begin
      r.cls = CLS_ALU_IMM16;
      r.len = 2'd2;
    end else if ((h & 16'hFC00) == 16'hC000) begin
      r.cls = CLS_ALU3_REG;
      r.len = 2'd2;
    end else if ((h & 16'hFC00) == 16'hE800) begin
      r.cls = CLS_ALU_IMM32;
      r.len = 2'd3;
    end else if ((h & 16'hFC00) == 16'hEC00) begin
      r.cls = CLS_ADD_IMM32;
      r.len = 2'd3;
    end else                                 r.cls = CLS_UNKNOWN;
    return r;
  endfunction

  function automatic logic [4:0] group_reg(logic [1:0] sel);
    logic [4:0] r;
    case (sel)
      2'd0:    r = 5'd0;
      2'd1:    r = 5'd6;
      2'd2:    r = 5'd16;
      default: r = 5'd24;
    endcase
    return r;
  endfunction

  function automatic out_t decode_instr(fmt_class_e cls, logic [1:0] len, logic [15:0] a,
                                        logic [15:0] b, logic [15:0] c, logic [31:0] addr);
    out_t        r;
    logic [22:0] off;
    r                  = '0;
    off                = {a[6:0], b};
    r.format_class     = cls;
    r.length_halfwords = len;
    r.instr_address    = addr;
    case (cls)
      CLS_RTS, CLS_BRANCH_R: begin
        r.dest_reg = a[4:0];
      end
      CLS_PUSH, CLS_POP, CLS_PUSHL, CLS_POPL: begin
        r.dest_reg = group_reg(a[6:5]);
      end
      CLS_LD_IND, CLS_ST_IND: begin
        r.opcode_field = {3'b0, a[10:9]};
        r.src_reg      = {1'b0, a[7:4]};
        r.dest_reg     = {1'b0, a[3:0]};
      end
      CLS_ALU_REG: begin
        r.opcode_field = a[12:8];
        r.src_reg      = {1'b0, a[7:4]};
        r.dest_reg     = {1'b0, a[3:0]};
      end
      CLS_BCOND, CLS_BL: begin
        if (cls == CLS_BCOND) r.condition = a[11:8];
        r.immediate     = {9'b0, off};
        r.branch_target = addr + {{8{off[22]}}, off, 1'b0};
      end
      CLS_ALU_IMM5: begin
        r.opcode_field = {1'b0, a[12:9]};
        r.immediate    = {27'b0, a[8:4]};
        r.dest_reg     = {1'b0, a[3:0]};
      end
      CLS_LD_OFF, CLS_ST_OFF: begin
        r.opcode_field = {3'b0, a[7:6]};
        r.dest_reg     = a[4:0];
        r.src_reg      = b[15:11];
        r.immediate    = {21'b0, b[10:0]};
      end
      CLS_ALU_IMM16: begin
        r.opcode_field = a[9:5];
        r.dest_reg     = a[4:0];
        r.immediate    = {16'b0, b};
      end
      CLS_ALU3_REG, CLS_ALU3_IMM6: begin
        r.opcode_field = a[9:5];
        r.dest_reg     = a[4:0];
        r.src_reg      = b[15:11];
        r.condition    = b[10:7];
        if (cls == CLS_ALU3_REG) r.second_reg = b[4:0];
        else                     r.immediate  = {26'b0, b[5:0]};
      end
      CLS_ALU_IMM32: begin
        r.opcode_field = a[9:5];
        r.dest_reg     = a[4:0];
        r.immediate    = {c, b};
      end
      CLS_ADD_IMM32: begin
        r.src_reg   = a[9:5];
        r.dest_reg  = a[4:0];
        r.immediate = {c, b};
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/vlid_outq.sv @@
// Three-entry result queue for the instruction decoder; takes up to two
// items per cycle and presents the oldest at a fixed head entry.
// Depends on vlid_pkg.
module vlid_outq import vlid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  out_t  push_first_i,
  input  out_t  push_second_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  out_t       ent_q [3];
  out_t       ent_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = ent_q[0];
  assign room_o      = cnt_q <= 2'd1;
  assign base        = cnt_q - {1'b0, pop};
  assign cnt_d       = base + {1'b0, push_i.first} + {1'b0, push_i.second};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ent_d[i] = ent_q[i];
      if (pop && i < 2) ent_d[i] = ent_q[i + 1];
      if (push_i.first && base == 2'(i)) ent_d[i] = push_first_i;
      if (push_i.second && (base + 2'd1) == 2'(i)) ent_d[i] = push_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) ent_q[i] <= ent_d[i];
  end

endmodule

@@ hdl/variable_length_instruction_decoder.sv @@
// Top level of the variable-length instruction decoder: halfword intake,
// instruction assembly state and decode. Depends on vlid_pkg and vlid_outq.
//
// Accepts one halfword per cycle while the result queue has room. An
// instruction is decoded in the cycle its last halfword is accepted and
// written into a three-entry result queue; in_ready_o is high while that
// queue holds at most one result, so with a sink that takes one result per
// cycle the block sustains one halfword per cycle. A halfword can cause two
// results (an unknown three-register form followed by its second halfword
// decoded afresh); both are pushed into the queue together. Writing
// cfg_wdata_i sets the stream start address and drops any partial
// instruction; after a halfword marked last the address returns to it.
module variable_length_instruction_decoder import vlid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] start_q;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] held_first_q, held_first_d;
  logic [15:0] held_second_q, held_second_d;
  fmt_class_e  held_class_q, held_class_d;
  logic [31:0] held_addr_q, held_addr_d;
  logic [31:0] next_addr_q, next_addr_d;

  logic        accept;
  logic        room;
  logic [15:0] h;
  logic        last;
  class_info_t ci;
  logic        st_emit;
  out_t        st_res;
  out_t        res0, res1;
  push_t       push;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = room;
  assign h          = in_data_i.halfword;
  assign last       = in_data_i.last_halfword;
  assign ci         = classify(h);
  assign st_emit    = (ci.len == 2'd1) || last;
  assign st_res     = (ci.len == 2'd1) ?
                      decode_instr(ci.cls, 2'd1, h, 16'd0, 16'd0, next_addr_q) :
                      decode_instr(CLS_TRUNC, 2'd1, 16'd0, 16'd0, 16'd0, next_addr_q);

  always_comb begin
    logic st_path;
    logic v0;
    logic v1;
    st_path       = 1'b0;
    v0            = 1'b0;
    v1            = 1'b0;
    res0          = st_res;
    res1          = st_res;
    pend_d        = pend_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    held_class_d  = held_class_q;
    held_addr_d   = held_addr_q;
    next_addr_d   = next_addr_q;
    if (cfg_we_i) begin
      next_addr_d = cfg_wdata_i;
      pend_d      = 2'd0;
    end else if (accept) begin
      next_addr_d = next_addr_q + 32'd2;
      case (pend_q)
        2'd0: begin
          st_path = 1'b1;
          v0      = st_emit;
          res0    = st_res;
        end
        2'd1: begin
          pend_d = 2'd0;
          if (held_class_q == CLS_ALU_IMM32 || held_class_q == CLS_ADD_IMM32) begin
            if (last) begin
              v0   = 1'b1;
              res0 = decode_instr(CLS_TRUNC, 2'd2, 16'd0, 16'd0, 16'd0, held_addr_q);
            end else begin
              held_second_d = h;
              pend_d        = 2'd2;
            end
          end else if (held_class_q == CLS_ALU3_REG) begin
            v0 = 1'b1;
            if (h[6:5] == 2'b00) begin
              res0 = decode_instr(CLS_ALU3_REG, 2'd2, held_first_q, h, 16'd0, held_addr_q);
            end else if (h[6]) begin
              res0 = decode_instr(CLS_ALU3_IMM6, 2'd2, held_first_q, h, 16'd0, held_addr_q);
            end else begin
              res0    = decode_instr(CLS_UNKNOWN, 2'd1, 16'd0, 16'd0, 16'd0, held_addr_q);
              st_path = 1'b1;
              v1      = st_emit;
              res1    = st_res;
            end
          end else begin
            v0   = 1'b1;
            res0 = decode_instr(held_class_q, 2'd2, held_first_q, h, 16'd0, held_addr_q);
          end
        end
        default: begin
          pend_d = 2'd0;
          v0     = 1'b1;
          res0   = decode_instr(held_class_q, 2'd3, held_first_q, held_second_q, h,
                                held_addr_q);
        end
      endcase
      if (st_path && !st_emit) begin
        held_first_d = h;
        held_class_d = ci.cls;
        held_addr_d  = next_addr_q;
        pend_d       = 2'd1;
      end
      if (last) begin
        pend_d      = 2'd0;
        next_addr_d = start_q;
      end
    end
    res0.end_of_run = !v1;
    res1.end_of_run = 1'b1;
    push.first      = v0;
    push.second     = v1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= 32'd0;
      pend_q        <= 2'd0;
      held_first_q  <= 16'd0;
      held_second_q <= 16'd0;
      held_class_q  <= CLS_NOP;
      held_addr_q   <= 32'd0;
      next_addr_q   <= 32'd0;
    end else begin
      if (cfg_we_i) start_q <= cfg_wdata_i;
      pend_q        <= pend_d;
      held_first_q  <= held_first_d;
      held_second_q <= held_second_d;
      held_class_q  <= held_class_d;
      held_addr_q   <= held_addr_d;
      next_addr_q   <= next_addr_d;
    end
  end

  vlid_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_first_i  (res0),
    .push_second_i (res1),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

`ifndef ASSERT_OFF
  a_trunc_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.format_class == CLS_TRUNC) |-> out_data_o.end_of_run)
    else $error("truncated result without end of run");

  a_unknown_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.format_class == CLS_UNKNOWN)
      |-> out_data_o.length_halfwords == 2'd1)
    else $error("unknown result with length other than one");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (pend_q == 2'd0 && next_addr_q == start_q))
    else $error("partial instruction kept after final halfword");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.second |-> (push.first && pend_q == 2'd1 && held_class_q == CLS_ALU3_REG))
    else $error("second result outside the unknown three-register case");
`endif

endmodule
